>>> rtl/core/hdlce_pkg.sv
// Package for the HDLC bit-stuffing frame encoder.
// Holds constants, action and segment codes, and the structs shared by the core modules.
// No dependencies.
`default_nettype none

package hdlce_pkg;

    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
    localparam logic [2:0]  RUN_MAX     = 3'd5;
    localparam logic [2:0]  RUN_SAT     = 3'd7;
    localparam logic [15:0] LIMIT_RESET = 16'd4096;

    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_DATA   = 2'd1;
    localparam logic [1:0] ACT_FLAG   = 2'd2;
    localparam logic [1:0] ACT_FOOTER = 2'd3;

    localparam logic [1:0] SEG_BYTE_LO = 2'd0;
    localparam logic [1:0] SEG_BYTE_HI = 2'd1;
    localparam logic [1:0] SEG_FLAG    = 2'd2;

    typedef struct packed {
        logic [15:0] crc_next;
        logic        room;
        logic [15:0] bits_inc;
        logic [2:0]  run_inc;
        logic        run_full;
    } bit_step_t;

    typedef struct packed {
        logic line_bit;
        logic bit_valid;
        logic stuffed;
        logic overflow;
        logic last;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/core/hdlce_if.sv
// Channel interfaces of the HDLC frame encoder: input item, result bit, limit write.
// Valid/ready handshake; a transaction completes when both are high at a clock edge.
// No dependencies.
`default_nettype none

interface hdlce_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface hdlce_out_if;
    logic valid;
    logic ready;
    logic line_bit;
    logic bit_valid;
    logic stuffed;
    logic overflow;
    logic last;

    modport source (output valid, output line_bit, output bit_valid, output stuffed,
                    output overflow, output last, input ready);
    modport sink (input valid, input line_bit, input bit_valid, input stuffed,
                  input overflow, input last, output ready);
endinterface

interface hdlce_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame_bit_limit;

    modport source (output valid, output frame_bit_limit, input ready);
    modport sink (input valid, input frame_bit_limit, output ready);
endinterface

`default_nettype wire

>>> rtl/core/hdlc_bit_stuffing_frame_encoder.sv
// Top level of the HDLC bit-stuffing frame encoder: sequencer, state and limit register.
// Depends on hdlce_pkg, hdlce_if, hdlce_bit_unit, hdlce_out_stage.
//
//  channel | dir | fields                                      | role
//  item    | in  | action[1:0], data_byte[7:0]                 | one action per transaction
//  result  | out | line_bit, bit_valid, stuffed, overflow, last | one line bit or empty result
//  cfg     | in  | frame_bit_limit[15:0]                       | limit write, always ready
//
// At most one result per cycle while the result channel takes them; accepting an item yields
// no result, each line bit or stuffed zero yields one, and a segment cut short by the bit limit
// yields none. A start item and an item cut short end with an empty result (overflow if cut).
// item.ready is high only between items. A stalled result channel freezes the sequencer.
// Reset: CRC 0xFFFF, run and bit count zero, limit 4096, no result pending.
`default_nettype none

module hdlc_bit_stuffing_frame_encoder
    import hdlce_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hdlce_in_if.sink    item,
    hdlce_out_if.source result,
    hdlce_cfg_if.sink   cfg
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_END  = 2'd2;

    logic [1:0]  state_reg,     state_next;
    logic [15:0] crc_reg,       crc_next;
    logic [2:0]  ones_run_reg,  ones_run_next;
    logic [15:0] bits_sent_reg, bits_sent_next;
    logic [15:0] limit_reg;
    logic [1:0]  seg_reg,       seg_next;
    logic        footer_reg,    footer_next;
    logic [7:0]  byte_reg,      byte_next;
    logic [7:0]  hi_reg,        hi_next;
    logic [2:0]  idx_reg,       idx_next;
    logic        pend_reg,      pend_next;
    logic        drop_reg,      drop_next;

    bit_step_t step;
    logic      cur_bit;
    logic      can_load;
    logic      load;
    res_t      ld_res;
    logic      last_seg;
    logic      bit_done;
    logic      drop_evt;
    logic      seg_end;

    assign cur_bit  = (seg_reg == SEG_FLAG) ? FLAG_BYTE[idx_reg] : byte_reg[idx_reg];
    assign last_seg = (seg_reg == SEG_FLAG) || ((seg_reg == SEG_BYTE_LO) && !footer_reg);

    hdlce_bit_unit u_bit_unit (
        .bit_in    (cur_bit),
        .crc       (crc_reg),
        .ones_run  (ones_run_reg),
        .bits_sent (bits_sent_reg),
        .limit     (limit_reg),
        .step      (step)
    );

    hdlce_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .ld_res   (ld_res),
        .can_load (can_load),
        .result   (result)
    );

    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        crc_next       = crc_reg;
        ones_run_next  = ones_run_reg;
        bits_sent_next = bits_sent_reg;
        seg_next       = seg_reg;
        footer_next    = footer_reg;
        byte_next      = byte_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        drop_next      = drop_reg;
        load           = 1'b0;
        ld_res         = '0;
        bit_done       = 1'b0;
        drop_evt       = 1'b0;
        seg_end        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    idx_next    = 3'd0;
                    pend_next   = 1'b0;
                    drop_next   = 1'b0;
                    footer_next = 1'b0;
                    byte_next   = item.data_byte;
                    case (item.action)
                        ACT_START:
                        begin
                            crc_next       = CRC_INIT;
                            ones_run_next  = 3'd0;
                            bits_sent_next = 16'd0;
                            state_next     = ST_END;
                        end
                        ACT_DATA:
                        begin
                            seg_next   = SEG_BYTE_LO;
                            state_next = ST_RUN;
                        end
                        ACT_FLAG:
                        begin
                            seg_next   = SEG_FLAG;
                            state_next = ST_RUN;
                        end
                        default:
                        begin
                            seg_next    = SEG_BYTE_LO;
                            footer_next = 1'b1;
                            byte_next   = ~crc_reg[7:0];
                            hi_next     = ~crc_reg[15:8];
                            state_next  = ST_RUN;
                        end
                    endcase
                end
            end

            ST_RUN:
            begin
                if (can_load)
                begin
                    if (pend_reg)
                    begin
                        if (step.room)
                        begin
                            load             = 1'b1;
                            ld_res.bit_valid = 1'b1;
                            ld_res.stuffed   = 1'b1;
                            bits_sent_next   = step.bits_inc;
                            ones_run_next    = 3'd0;
                            pend_next        = 1'b0;
                            bit_done         = 1'b1;
                        end
                        else
                        begin
                            drop_evt = 1'b1;
                        end
                    end
                    else if (seg_reg != SEG_FLAG)
                    begin
                        crc_next = step.crc_next;
                        if (!step.room)
                        begin
                            drop_evt = 1'b1;
                        end
                        else
                        begin
                            load             = 1'b1;
                            ld_res.line_bit  = cur_bit;
                            ld_res.bit_valid = 1'b1;
                            bits_sent_next   = step.bits_inc;
                            if (cur_bit)
                            begin
                                ones_run_next = step.run_inc;
                                if (step.run_full)
                                begin
                                    pend_next = 1'b1;
                                end
                                else
                                begin
                                    bit_done = 1'b1;
                                end
                            end
                            else
                            begin
                                ones_run_next = 3'd0;
                                bit_done      = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (step.room)
                        begin
                            load             = 1'b1;
                            ld_res.line_bit  = cur_bit;
                            ld_res.bit_valid = 1'b1;
                            bits_sent_next   = step.bits_inc;
                            bit_done         = 1'b1;
                        end
                        else
                        begin
                            drop_evt = 1'b1;
                        end
                    end

                    if (bit_done)
                    begin
                        if (idx_reg == 3'd7)
                        begin
                            seg_end = 1'b1;
                        end
                        else
                        begin
                            idx_next = idx_reg + 3'd1;
                        end
                    end
                    if (drop_evt)
                    begin
                        drop_next = 1'b1;
                        seg_end   = 1'b1;
                    end
                    ld_res.last = bit_done && (idx_reg == 3'd7) && last_seg && !drop_reg;

                    if (seg_end)
                    begin
                        idx_next  = 3'd0;
                        pend_next = 1'b0;
                        if (last_seg)
                        begin
                            state_next = (drop_reg || drop_evt) ? ST_END : ST_IDLE;
                        end
                        else if (seg_reg == SEG_BYTE_LO)
                        begin
                            seg_next  = SEG_BYTE_HI;
                            byte_next = hi_reg;
                        end
                        else
                        begin
                            seg_next = SEG_FLAG;
                        end
                    end
                end
            end

            ST_END:
            begin
                if (can_load)
                begin
                    load            = 1'b1;
                    ld_res.overflow = drop_reg;
                    ld_res.last     = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            crc_reg       <= CRC_INIT;
            ones_run_reg  <= 3'd0;
            bits_sent_reg <= 16'd0;
            limit_reg     <= LIMIT_RESET;
            seg_reg       <= SEG_BYTE_LO;
            footer_reg    <= 1'b0;
            idx_reg       <= 3'd0;
            pend_reg      <= 1'b0;
            drop_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            crc_reg       <= crc_next;
            ones_run_reg  <= ones_run_next;
            bits_sent_reg <= bits_sent_next;
            seg_reg       <= seg_next;
            footer_reg    <= footer_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            drop_reg      <= drop_next;
            if (cfg.valid)
            begin
                limit_reg <= cfg.frame_bit_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        hi_reg   <= hi_next;
    end

    a_bit_counts: assert property (@(posedge clk) disable iff (!rst_n)
        load && ld_res.bit_valid |=> bits_sent_reg == $past(bits_sent_reg) + 16'd1)
        else $error("line bit emitted without bit count step");

    a_stuff_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        load && ld_res.stuffed |=> ones_run_reg == 3'd0)
        else $error("stuffed zero did not clear ones run");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        load && ld_res.last |=> state_reg == ST_IDLE)
        else $error("last result loaded but item still in progress");

    a_ovf_empty: assert property (@(posedge clk) disable iff (!rst_n)
        load && ld_res.overflow |-> ld_res.last && !ld_res.bit_valid && drop_reg)
        else $error("overflow result malformed");

endmodule

`default_nettype wire

>>> rtl/core/hdlce_bit_unit.sv
// Shared per-bit unit: one CRC-16 step, limit compare, bit count and ones-run increment.
// Used once per cycle by the sequencer in the top level. Depends on hdlce_pkg.
`default_nettype none

module hdlce_bit_unit
    import hdlce_pkg::*;
(
    input  wire logic        bit_in,
    input  wire logic [15:0] crc,
    input  wire logic [2:0]  ones_run,
    input  wire logic [15:0] bits_sent,
    input  wire logic [15:0] limit,
    output bit_step_t        step
);

    logic [15:0] mix;

    always_comb
    begin
        mix = crc ^ {15'd0, bit_in};
        if (mix[0])
        begin
            step.crc_next = (mix >> 1) ^ CRC_POLY;
        end
        else
        begin
            step.crc_next = mix >> 1;
        end
        step.room     = bits_sent < limit;
        step.bits_inc = bits_sent + 16'd1;
        step.run_inc  = (ones_run == RUN_SAT) ? RUN_SAT : ones_run + 3'd1;
        step.run_full = step.run_inc >= RUN_MAX;
    end

endmodule

`default_nettype wire

>>> rtl/core/hdlce_out_stage.sv
// Output register of the HDLC frame encoder: holds one result transaction until taken.
// Depends on hdlce_pkg and hdlce_out_if.
`default_nettype none

module hdlce_out_stage
    import hdlce_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire res_t    ld_res,
    output logic         can_load,
    hdlce_out_if.source  result
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign can_load = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= ld_res;
        end
    end

    assign result.valid     = valid_reg;
    assign result.line_bit  = res_reg.line_bit;
    assign result.bit_valid = res_reg.bit_valid;
    assign result.stuffed   = res_reg.stuffed;
    assign result.overflow  = res_reg.overflow;
    assign result.last      = res_reg.last;

endmodule

`default_nettype wire
